/* hw/rtl/triangle_voxel_test_assert.svh */
// assertion macros for the triangle voxel test block
// expects signals named clk and rst_n in the including module
`ifndef TRIANGLE_VOXEL_TEST_ASSERT_SVH
`define TRIANGLE_VOXEL_TEST_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tvt_pkg.sv */
// shared widths, types and register indexes for the triangle voxel test
// no dependencies
package tvt_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;
  localparam int VERT_BITS  = 17;
  localparam int CFG_W      = 3 * VERT_BITS;
  localparam int CFG_IDX_W  = 2;

  // voxel position in 1/16 units
  localparam int POS_W  = COORD_BITS + FRAC_BITS;
  // edge and offset vectors
  localparam int T_W    = 18;
  // cross products
  localparam int N_W    = 2 * T_W;
  // half of a multiplier operand
  localparam int HALF   = N_W / 2;
  // full wide products
  localparam int P_W    = 2 * N_W;
  // dot products and final compares
  localparam int S_W    = P_W + 4;
  // L1 norm of the normal
  localparam int L1_W   = N_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_C = 2'd2;

  typedef logic signed [VERT_BITS-1:0] vfld_t;
  typedef logic signed [T_W-1:0]       crd_t;
  typedef logic signed [N_W-1:0]       nrm_t;
  typedef logic signed [P_W-1:0]       prod_t;
  typedef logic signed [S_W-1:0]       sum_t;

  // one signed coordinate out of a packed z:y:x vertex
  function automatic vfld_t vert_field(input logic [CFG_W-1:0] r, input int k);
    return vfld_t'(r[k*VERT_BITS +: VERT_BITS]);
  endfunction

endpackage

/* hw/rtl/triangle_voxel_test.sv */
// triangle voxel test top level: seven-stage pipelined membership test
// depends on tvt_pkg and triangle_voxel_test_assert.svh
`include "triangle_voxel_test_assert.svh"
// Usage
//   cfg_we/cfg_index/cfg_data write the three triangle vertices (index 0..2,
//   51 bits each, packed z:y:x signed 17-bit fields); other indexes are
//   dropped. write them only while no request is in flight.
//   in_valid/in_stall carry voxel requests (in_voxel_x/y/z); a request is
//   taken on a clock edge with in_valid high and in_stall low.
//   out_valid/out_stall return one inside_res bit per request, in order.
// Pipeline and throughput
//   seven register stages (0..6); a request enters stage 0 when taken and
//   its result shows on the output once it reaches stage 6.
//   one request per clock while out_stall is low; the depth is set by the
//   36x36 products, split into four 18x18 partials over two stages.
// Reset and stall
//   rst_n (synchronous, low) clears the vertices to zero and empties the
//   pipe. each stage moves on when it is empty or its successor moves, so a
//   stalled output keeps its result and the stages behind it keep filling
//   bubbles; in_stall rises only when every stage holds a request.
module triangle_voxel_test (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tvt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tvt_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tvt_pkg::COORD_BITS-1:0]  in_voxel_x,
  input  logic [tvt_pkg::COORD_BITS-1:0]  in_voxel_y,
  input  logic [tvt_pkg::COORD_BITS-1:0]  in_voxel_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_inside_res
);
  import tvt_pkg::*;

  localparam int NST   = 7;
  localparam int NLANE = 12;
  // lane groups of the dot products
  localparam int SUM_D  = 0;
  localparam int SUM_A  = 1;
  localparam int SUM_B  = 2;
  localparam int SUM_TN = 3;
  localparam int NSUM   = 4;
  // cross product index pairs
  localparam int J_IDX [3] = '{1, 2, 0};
  localparam int K_IDX [3] = '{2, 0, 1};

  // triangle vertices
  logic [CFG_W-1:0] vtx_a_r, vtx_b_r, vtx_c_r;

  // pipeline control
  logic [NST-1:0] v_r;
  logic [NST-1:0] stage_en;

  // stage 0: offset and edge vectors
  crd_t t0_r [3];
  crd_t u0_r [3];
  crd_t v0_r [3];
  crd_t t0_nxt [3];
  crd_t u0_nxt [3];
  crd_t v0_nxt [3];

  // stage 1: cross product terms
  nrm_t pn1_r  [6];
  nrm_t ptv1_r [6];
  nrm_t put1_r [6];
  crd_t t1_r   [3];

  // stage 2: normal, t x v, u x t
  nrm_t n2_r  [3];
  nrm_t tv2_r [3];
  nrm_t ut2_r [3];
  crd_t t2_r  [3];

  // stage 3: partial products of the wide multiplies
  logic        [N_W-1:0] pll3_r [NLANE];
  logic signed [N_W:0]   plh3_r [NLANE];
  logic signed [N_W:0]   phl3_r [NLANE];
  logic signed [N_W-1:0] phh3_r [NLANE];
  logic        [N_W-1:0] pll3_nxt [NLANE];
  logic signed [N_W:0]   plh3_nxt [NLANE];
  logic signed [N_W:0]   phl3_nxt [NLANE];
  logic signed [N_W-1:0] phh3_nxt [NLANE];
  logic [L1_W-1:0]       l13_r, l13_nxt;
  logic                  nz3_r;
  nrm_t                  ma [NLANE];
  nrm_t                  mb [NLANE];

  // stage 4: full products
  prod_t           prod4_r [NLANE];
  logic [L1_W-1:0] l14_r;
  logic            nz4_r;

  // stage 5: dot products d, A, B and t.n
  sum_t            sum5_r [NSUM];
  logic [L1_W-1:0] l15_r;
  logic            nz5_r;

  // stage 6: result
  logic res6_r, res6_nxt;

  // stage k loads when it is empty or its request moves on
  always_comb begin
    stage_en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      stage_en[k] = !v_r[k] || stage_en[k+1];
    end
  end

  assign in_stall       = !stage_en[0];
  assign out_valid      = v_r[NST-1];
  assign out_inside_res = res6_r;

  // configuration writes and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_a_r <= '0;
      vtx_b_r <= '0;
      vtx_c_r <= '0;
      v_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VERTEX_A: vtx_a_r <= cfg_data;
          CFG_VERTEX_B: vtx_b_r <= cfg_data;
          CFG_VERTEX_C: vtx_c_r <= cfg_data;
          default: ;
        endcase
      end
      if (stage_en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (stage_en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: t = voxel*16 - a, u = b - a, v = c - a
  always_comb begin
    logic [COORD_BITS-1:0] vox [3];
    logic [POS_W-1:0]      pos;
    crd_t                  a_ext;
    vox[0] = in_voxel_x;
    vox[1] = in_voxel_y;
    vox[2] = in_voxel_z;
    for (int k = 0; k < 3; k++) begin
      pos       = {vox[k], {FRAC_BITS{1'b0}}};
      a_ext     = crd_t'(vert_field(vtx_a_r, k));
      t0_nxt[k] = crd_t'({{(T_W-POS_W){1'b0}}, pos}) - a_ext;
      u0_nxt[k] = crd_t'(vert_field(vtx_b_r, k)) - a_ext;
      v0_nxt[k] = crd_t'(vert_field(vtx_c_r, k)) - a_ext;
    end
  end

  // multiplier lane operands: n.n, (t x v).n, (u x t).n, t.n
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i]     = n2_r[i];
      ma[3+i]   = tv2_r[i];
      ma[6+i]   = ut2_r[i];
      ma[9+i]   = nrm_t'(t2_r[i]);
      mb[i]     = n2_r[i];
      mb[3+i]   = n2_r[i];
      mb[6+i]   = n2_r[i];
      mb[9+i]   = n2_r[i];
    end
  end

  // split each 36x36 product into four partials of 18-bit halves
  always_comb begin
    logic        [HALF-1:0] al, bl;
    logic signed [HALF-1:0] ah, bh;
    for (int k = 0; k < NLANE; k++) begin
      al          = ma[k][HALF-1:0];
      bl          = mb[k][HALF-1:0];
      ah          = ma[k][N_W-1:HALF];
      bh          = mb[k][N_W-1:HALF];
      pll3_nxt[k] = al * bl;
      plh3_nxt[k] = ah * $signed({1'b0, bl});
      phl3_nxt[k] = $signed({1'b0, al}) * bh;
      phh3_nxt[k] = ah * bh;
    end
  end

  // L1 norm of the normal
  always_comb begin
    logic [N_W-1:0] mag [3];
    for (int i = 0; i < 3; i++) begin
      mag[i] = n2_r[i][N_W-1] ? N_W'(-n2_r[i]) : N_W'(n2_r[i]);
    end
    l13_nxt = L1_W'(mag[0]) + L1_W'(mag[1]) + L1_W'(mag[2]);
  end

  // final compares: nonzero normal, A >= 0, B >= 0, A + B <= d, 2|t.n| <= l1 * 16
  always_comb begin
    sum_t rest, tn_abs, slack;
    rest     = sum5_r[SUM_D] - sum5_r[SUM_A] - sum5_r[SUM_B];
    tn_abs   = sum5_r[SUM_TN][S_W-1] ? -sum5_r[SUM_TN] : sum5_r[SUM_TN];
    slack    = sum_t'({l15_r, {FRAC_BITS{1'b0}}}) - (tn_abs <<< 1);
    res6_nxt = nz5_r && !sum5_r[SUM_A][S_W-1] && !sum5_r[SUM_B][S_W-1] &&
               !rest[S_W-1] && !slack[S_W-1];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      t0_r <= t0_nxt;
      u0_r <= u0_nxt;
      v0_r <= v0_nxt;
    end
    if (stage_en[1]) begin
      for (int i = 0; i < 3; i++) begin
        pn1_r[2*i]    <= u0_r[J_IDX[i]] * v0_r[K_IDX[i]];
        pn1_r[2*i+1]  <= u0_r[K_IDX[i]] * v0_r[J_IDX[i]];
        ptv1_r[2*i]   <= t0_r[J_IDX[i]] * v0_r[K_IDX[i]];
        ptv1_r[2*i+1] <= t0_r[K_IDX[i]] * v0_r[J_IDX[i]];
        put1_r[2*i]   <= u0_r[J_IDX[i]] * t0_r[K_IDX[i]];
        put1_r[2*i+1] <= u0_r[K_IDX[i]] * t0_r[J_IDX[i]];
      end
      t1_r <= t0_r;
    end
    if (stage_en[2]) begin
      for (int i = 0; i < 3; i++) begin
        n2_r[i]  <= pn1_r[2*i] - pn1_r[2*i+1];
        tv2_r[i] <= ptv1_r[2*i] - ptv1_r[2*i+1];
        ut2_r[i] <= put1_r[2*i] - put1_r[2*i+1];
      end
      t2_r <= t1_r;
    end
    if (stage_en[3]) begin
      pll3_r <= pll3_nxt;
      plh3_r <= plh3_nxt;
      phl3_r <= phl3_nxt;
      phh3_r <= phh3_nxt;
      l13_r  <= l13_nxt;
      nz3_r  <= |{n2_r[0], n2_r[1], n2_r[2]};
    end
    if (stage_en[4]) begin
      for (int k = 0; k < NLANE; k++) begin
        prod4_r[k] <= (prod_t'(phh3_r[k]) <<< (2*HALF)) +
                      (prod_t'(plh3_r[k]) <<< HALF) +
                      (prod_t'(phl3_r[k]) <<< HALF) +
                      prod_t'(pll3_r[k]);
      end
      l14_r <= l13_r;
      nz4_r <= nz3_r;
    end
    if (stage_en[5]) begin
      for (int g = 0; g < NSUM; g++) begin
        sum5_r[g] <= sum_t'(prod4_r[3*g]) + sum_t'(prod4_r[3*g+1]) +
                     sum_t'(prod4_r[3*g+2]);
      end
      l15_r <= l14_r;
      nz5_r <= nz4_r;
    end
    if (stage_en[6]) begin
      res6_r <= res6_nxt;
    end
  end

  // the input only backs up when every stage is full and the output waits
  `TVT_ASSERT_NOW(a_stall_only_full, in_stall, (&v_r) && out_stall, "stall with a bubble")
  // a degenerate triangle never reports a hit
  `TVT_ASSERT_NEXT(a_degenerate_false, v_r[5] && stage_en[6] && !nz5_r, !out_inside_res, "degenerate hit")
  // a bubble moving into the output stage leaves no result behind
  `TVT_ASSERT_NEXT(a_no_phantom_out, !v_r[5] && stage_en[6], !out_valid, "result from a bubble")

endmodule
